// ===== rtl/mhtw_pkg.sv =====
// ----------------------------------------------------------------------------
// mhtw_pkg
// Shared widths, Q1.31 constants and register codes for the Metropolis-
// Hastings transition weight pipeline.
// ----------------------------------------------------------------------------
package mhtw_pkg;

  // Q1.31 fixed point: 2^31 stands for 1.0
  localparam int unsigned Q_W = 32;
  localparam int unsigned Q_FRAC = 31;
  localparam logic [Q_W-1:0] Q_ONE = {1'b1, {(Q_W-1){1'b0}}};

  // Default number of binary features per table entry
  localparam int unsigned NUM_FEATURES_DEF = 10;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_LABEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_FEATURE = 1'b1;

  // Clamp a mismatch probability to 1.0
  function automatic logic [Q_W-1:0] sat_delta(input logic [Q_W-1:0] d);
    sat_delta = (d > Q_ONE) ? Q_ONE : d;
  endfunction

endpackage

// ===== rtl/mh_transition_weight.sv =====
// ----------------------------------------------------------------------------
// mh_transition_weight
// Streams table entries and returns min(p, p_obs) / p_obs times the kernel
// factor built from per-bit match / mismatch probabilities, all in Q1.31.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transfer on            | Payload
//  --------+-----------+------------------------+------------------------------
//  in_     | slave     | in_tvalid & in_tready  | entry, probabilities, observed
//  out_    | master    | out_tvalid & out_tready| Q1.31 weight
//  cfg_    | write     | cfg_we                 | delta_label / delta_feature
//
//  Throughput is one entry per cycle while the skid buffer is empty. The
//  pipeline has one capture stage, 32 restoring-divider stages (one quotient
//  bit each), NUM_FEATURES + 1 multiplier stages (one 32x32 product each)
//  and the output register. Reset (synchronous, active low) clears all valid
//  bits and both deltas. A one-entry skid buffer behind the output register
//  holds a result when out_tready is low; in_tready drops only while it
//  is occupied, and the whole pipeline then holds.
//
module mh_transition_weight
  import mhtw_pkg::*;
#(
  parameter int unsigned NUM_FEATURES = NUM_FEATURES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  // entry_index, prob_entry, prob_observed, observed_label,
  // observed_features, zero pad to whole bytes
  input  logic [((2*NUM_FEATURES+66+7)/8)*8-1:0] in_tdata,

  output logic                 out_tvalid,
  input  logic                 out_tready,
  // weight
  output logic [Q_W-1:0]       out_tdata,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_wdata
);

  localparam int unsigned IDX_W = NUM_FEATURES + 1;
  localparam int unsigned PE_LSB = IDX_W;
  localparam int unsigned PO_LSB = PE_LSB + Q_W;
  localparam int unsigned OL_LSB = PO_LSB + Q_W;
  localparam int unsigned OF_LSB = OL_LSB + 1;
  localparam int unsigned DIV_STEPS = Q_W;
  localparam int unsigned MUL_STEPS = NUM_FEATURES + 1;

  // --------------------------------------------------------------------------
  // Configuration: store saturated factors for match and mismatch
  // --------------------------------------------------------------------------
  logic [Q_W-1:0] lbl_keep_r, lbl_flip_r, ftr_keep_r, ftr_flip_r;
  logic [Q_W-1:0] cfg_sat;

  assign cfg_sat = sat_delta(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbl_keep_r <= Q_ONE;
      lbl_flip_r <= '0;
      ftr_keep_r <= Q_ONE;
      ftr_flip_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELTA_LABEL: begin
          lbl_keep_r <= Q_ONE - cfg_sat;
          lbl_flip_r <= cfg_sat;
        end
        CFG_DELTA_FEATURE: begin
          ftr_keep_r <= Q_ONE - cfg_sat;
          ftr_flip_r <= cfg_sat;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: hold everything while the skid buffer is occupied
  // --------------------------------------------------------------------------
  logic skid_vld_r;
  logic adv;

  assign adv = !skid_vld_r;
  assign in_tready = adv;

  // --------------------------------------------------------------------------
  // Capture stage (divider slot 0): unpack, take min, mark matches
  // --------------------------------------------------------------------------
  logic             dv_vld_r   [0:DIV_STEPS];
  logic [Q_W-1:0]   dv_rem_r   [0:DIV_STEPS];
  logic [Q_W-1:0]   dv_q_r     [0:DIV_STEPS];
  logic [Q_W-1:0]   dv_pobs_r  [0:DIV_STEPS];
  logic             dv_zero_r  [0:DIV_STEPS];
  logic [IDX_W-1:0] dv_match_r [0:DIV_STEPS];

  logic [IDX_W-1:0] in_idx;
  logic [Q_W-1:0]   in_p, in_pobs;
  logic [IDX_W-1:0] in_obs;

  assign in_idx  = in_tdata[IDX_W-1:0];
  assign in_p    = in_tdata[PE_LSB +: Q_W];
  assign in_pobs = in_tdata[PO_LSB +: Q_W];
  assign in_obs  = {in_tdata[OF_LSB +: NUM_FEATURES], in_tdata[OL_LSB]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0]   <= (in_p < in_pobs) ? in_p : in_pobs;
      dv_q_r[0]     <= '0;
      dv_pobs_r[0]  <= in_pobs;
      dv_zero_r[0]  <= (in_pobs == '0);
      dv_match_r[0] <= ~(in_idx ^ in_obs);
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage, MSB (weight 1.0) first
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [Q_W:0]   trial, diff;
    logic           ge;
    logic [Q_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign trial = {1'b0, dv_rem_r[k]};
    end else begin : g_rest
      assign trial = {dv_rem_r[k], 1'b0};
    end

    always_comb begin
      diff    = trial - {1'b0, dv_pobs_r[k]};
      ge      = (trial >= {1'b0, dv_pobs_r[k]});
      rem_nxt = ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k+1]   <= rem_nxt;
        dv_q_r[k+1]     <= {dv_q_r[k][Q_W-2:0], ge};
        dv_pobs_r[k+1]  <= dv_pobs_r[k];
        dv_zero_r[k+1]  <= dv_zero_r[k];
        dv_match_r[k+1] <= dv_match_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Kernel product: label factor first, then features 0 and up
  // --------------------------------------------------------------------------
  logic             ml_vld_r   [1:MUL_STEPS];
  logic [Q_W-1:0]   ml_w_r     [1:MUL_STEPS];
  logic [IDX_W-1:0] ml_match_r [1:MUL_STEPS];

  for (genvar j = 0; j < MUL_STEPS; j++) begin : g_mul
    logic             src_vld;
    logic [Q_W-1:0]   src_w;
    logic [IDX_W-1:0] src_match;
    logic [Q_W-1:0]   fac;
    logic [2*Q_W-1:0] prod;

    if (j == 0) begin : g_src_div
      // Zero observed probability gives a ratio of one
      assign src_vld   = dv_vld_r[DIV_STEPS];
      assign src_w     = dv_zero_r[DIV_STEPS] ? Q_ONE : dv_q_r[DIV_STEPS];
      assign src_match = dv_match_r[DIV_STEPS];
      assign fac       = src_match[j] ? lbl_keep_r : lbl_flip_r;
    end else begin : g_src_mul
      assign src_vld   = ml_vld_r[j];
      assign src_w     = ml_w_r[j];
      assign src_match = ml_match_r[j];
      assign fac       = src_match[j] ? ftr_keep_r : ftr_flip_r;
    end

    assign prod = src_w * fac;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ml_vld_r[j+1] <= 1'b0;
      end else if (adv) begin
        ml_vld_r[j+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ml_w_r[j+1]     <= prod[Q_FRAC +: Q_W];
        ml_match_r[j+1] <= src_match;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid buffer
  // --------------------------------------------------------------------------
  logic           out_vld_r;
  logic [Q_W-1:0] out_data_r;
  logic [Q_W-1:0] skid_data_r;
  logic           last_vld;
  logic [Q_W-1:0] last_w;

  assign last_vld = ml_vld_r[MUL_STEPS];
  assign last_w   = ml_w_r[MUL_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (adv) begin
      // Park the arriving result if the current one is not taken
      if (out_vld_r && !out_tready) begin
        skid_vld_r <= last_vld;
      end else begin
        out_vld_r <= last_vld;
      end
    end else if (out_tready) begin
      // Drain the skid buffer into the output register
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (out_vld_r && !out_tready) begin
        skid_data_r <= last_w;
      end else begin
        out_data_r <= last_w;
      end
    end else if (out_tready) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream check of the transition weight pipeline. Entries go in over the
// input stream. Each accepted entry gets its expected Q1.31 weight from a
// bit-exact predictor: a truncated ratio, then a label factor, then one
// factor per feature. Weights coming out are checked in order against those
// expectations. The run covers directed corners (zero and oversized
// probabilities, saturated deltas, all-match and all-mismatch entries),
// then random traffic with idle cycles on both sides and a long output hold.
// ----------------------------------------------------------------------------
module testbench;
  import mhtw_pkg::*;

  localparam int unsigned NF = NUM_FEATURES_DEF;
  localparam int unsigned NIDX = NF + 1;
  localparam int unsigned IN_W = ((2*NF+66+7)/8)*8;
  localparam int unsigned LATENCY = NF + 35;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  // one table entry, index in the lowest bits
  typedef struct packed {
    logic [NF-1:0]  features;
    logic           label;
    logic [Q_W-1:0] p_obs;
    logic [Q_W-1:0] p_entry;
    logic [NF:0]    index;
  } entry_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // entry_index, prob_entry, prob_observed, observed_label,
  // observed_features, zero pad
  logic [IN_W-1:0]      in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  // weight
  logic [Q_W-1:0]       out_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [Q_W-1:0]       cfg_wdata;

  // predictor copy of the delta registers
  logic [Q_W-1:0] model_delta_label;
  logic [Q_W-1:0] model_delta_feature;

  logic [Q_W-1:0] expected_weights[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int error_count = 0;
  int entries_sent = 0;
  int weights_checked = 0;
  int settings_used = 1;
  int input_stalls = 0;
  int cycle_count = 0;

  mh_transition_weight #(
    .NUM_FEATURES(NF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Multiply the running weight by one bit's match or mismatch factor.
  // Deltas above 1.0 clamp to 1.0; the product is truncated.
  function automatic logic [63:0] kernel_step(logic [63:0] w, logic entry_bit,
                                              logic obs_bit, logic [Q_W-1:0] d);
    logic [63:0] dsat;
    logic [63:0] f;
    dsat = (d > Q_ONE) ? 64'(Q_ONE) : 64'(d);
    f = (entry_bit == obs_bit) ? (64'(Q_ONE) - dsat) : dsat;
    return (w * f) >> Q_FRAC;
  endfunction

  function automatic logic [Q_W-1:0] predict_weight(entry_t e);
    logic [63:0] w;
    logic [63:0] m;
    // ratio min(p, p_obs) / p_obs, taken as 1.0 when p_obs is zero
    if (e.p_obs == '0) begin
      w = 64'(Q_ONE);
    end else begin
      m = (e.p_entry < e.p_obs) ? 64'(e.p_entry) : 64'(e.p_obs);
      w = (m << Q_FRAC) / 64'(e.p_obs);
    end
    w = kernel_step(w, e.index[0], e.label, model_delta_label);
    for (int i = 0; i < NF; i++) begin
      w = kernel_step(w, e.index[i+1], e.features[i], model_delta_feature);
    end
    return w[Q_W-1:0];
  endfunction

  function automatic entry_t make_entry(logic [NF:0] idx, logic [Q_W-1:0] p,
                                        logic [Q_W-1:0] pobs, logic lab,
                                        logic [NF-1:0] feat);
    entry_t e;
    e.index = idx;
    e.p_entry = p;
    e.p_obs = pobs;
    e.label = lab;
    e.features = feat;
    return e;
  endfunction

  // Mostly entries close to the observed point so the weight survives the
  // kernel, the rest fully random; probabilities mix the special cases.
  function automatic entry_t random_entry();
    entry_t e;
    logic [NF-1:0] flips;
    flips = '0;
    e.label = 1'($urandom_range(0, 1));
    e.features = NF'($urandom_range(0, (1 << NF) - 1));
    if ($urandom_range(0, 3) == 0) begin
      e.index = NIDX'($urandom_range(0, (1 << (NF + 1)) - 1));
    end else begin
      if ($urandom_range(0, 1) == 1) flips[$urandom_range(0, NF-1)] = 1'b1;
      e.index = {e.features ^ flips, e.label ^ ($urandom_range(0, 3) == 0)};
    end
    case ($urandom_range(0, 9))
      0: begin
        e.p_entry = $urandom;
        e.p_obs = '0;
      end
      1: begin
        e.p_obs = $urandom_range(1, Q_ONE);
        e.p_entry = e.p_obs;
      end
      2: begin
        e.p_entry = $urandom;
        e.p_obs = $urandom;
      end
      default: begin
        e.p_entry = $urandom_range(0, Q_ONE);
        e.p_obs = $urandom_range(0, Q_ONE);
      end
    endcase
    return e;
  endfunction

  // mostly small deltas so weights stay visible, sometimes above 1.0
  function automatic logic [Q_W-1:0] random_delta();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, Q_ONE);
      default: return $urandom_range(0, 32'h2000_0000);
    endcase
  endfunction

  // Offer one entry after a random number of idle cycles, hold until the
  // transfer, then record its expected weight.
  task automatic send_entry(entry_t e);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'(e);
    do @(posedge clk); while (!in_tready);
    expected_weights.push_back(predict_weight(e));
    entries_sent++;
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_weights.size() != 0) @(posedge clk);
  endtask

  // Write both deltas once the pipeline is empty.
  task automatic set_deltas(logic [Q_W-1:0] dl, logic [Q_W-1:0] df);
    stop_input();
    wait_drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DELTA_LABEL;
    cfg_wdata <= dl;
    @(negedge clk);
    cfg_index <= CFG_DELTA_FEATURE;
    cfg_wdata <= df;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_delta_label = dl;
    model_delta_feature = df;
    settings_used++;
  endtask

  // Both deltas still zero from reset: full match keeps the ratio,
  // any mismatch kills the weight.
  task automatic test_reset_deltas();
    send_entry(make_entry(11'h7FF, 32'h4000_0000, Q_ONE, 1'b1, 10'h3FF));
    send_entry(make_entry(11'h000, '0, '0, 1'b0, 10'h000));
    send_entry(make_entry(11'h001, 32'h1234_5678, 32'h2345_6789, 1'b0, 10'h000));
  endtask

  task automatic test_directed_corners();
    set_deltas(32'h0CCC_CCCD, 32'h1999_999A);
    send_entry(make_entry(11'h2AA, '0, 32'h1234_5678, 1'b0, 10'h155));
    // entry probability above the observed one
    send_entry(make_entry(11'h2AA, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 10'h155));
    send_entry(make_entry(11'h555, Q_ONE, Q_ONE, 1'b1, 10'h2AA));
    // probabilities above 1.0
    send_entry(make_entry(11'h555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 10'h2AA));
    send_entry(make_entry(11'h555, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 10'h2AA));
    send_entry(make_entry(11'h001, 32'hFFFF_FFFF, 32'h8000_0001, 1'b1, 10'h000));
    // every bit differs
    send_entry(make_entry(11'h7FF, 32'h3000_0000, 32'h6000_0000, 1'b0, 10'h000));
    // zero observed probability, label differs only
    send_entry(make_entry(11'h000, 32'h5555_5555, '0, 1'b1, 10'h000));
    send_entry(make_entry(11'h2AA, 32'h3FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 10'h155));

    // deltas at exactly 1.0: only an all-mismatch entry keeps weight
    set_deltas(Q_ONE, Q_ONE);
    send_entry(make_entry(11'h7FF, Q_ONE, Q_ONE, 1'b0, 10'h000));
    send_entry(make_entry(11'h7FE, Q_ONE, Q_ONE, 1'b0, 10'h000));

    // deltas above 1.0 saturate to 1.0
    set_deltas(32'hFFFF_FFFF, 32'h8000_0001);
    send_entry(make_entry(11'h7FF, 32'h2000_0000, 32'h4000_0000, 1'b0, 10'h000));
    send_entry(make_entry(11'h3FF, 32'h2000_0000, 32'h4000_0000, 1'b1, 10'h1FF));

    // label always flips, features always match
    set_deltas(Q_ONE, '0);
    send_entry(make_entry(11'h7FE, 32'h6000_0000, 32'h7000_0000, 1'b1, 10'h3FF));
    send_entry(make_entry(11'h7FF, 32'h6000_0000, 32'h7000_0000, 1'b1, 10'h3FF));
  endtask

  task automatic test_random_traffic(int count, int send_pct, int recv_pct,
                                     bit equal_deltas);
    logic [Q_W-1:0] d;
    d = random_delta();
    // equal deltas give the plain class kernel
    if (equal_deltas) set_deltas(d, d);
    else set_deltas(random_delta(), d);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_entry(random_entry());
  endtask

  // Hold the output long enough to fill the pipeline and stall the input.
  task automatic test_output_backpressure();
    set_deltas(32'h0800_0000, 32'h0400_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 150;
    repeat (80) send_entry(random_entry());
    // pause the sender until every weight is back
    stop_input();
    wait_drain();
  endtask

  // receiver: random stalls plus an explicit long hold
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each weight transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_weights.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected weight %h at cycle %0d", out_tdata, cycle_count);
      end else begin
        if (out_tdata !== expected_weights[0]) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("weight %0d mismatch: expected %h, got %h",
                     weights_checked, expected_weights[0], out_tdata);
        end
        void'(expected_weights.pop_front());
        weights_checked++;
      end
    end
  end

  // watchdog and input stall count
  always @(posedge clk) begin
    cycle_count++;
    if (in_tvalid && !in_tready) input_stalls++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d weights outstanding",
               cycle_count, expected_weights.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DELTA_LABEL;
    cfg_wdata = '0;
    model_delta_label = '0;
    model_delta_feature = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_deltas();
    test_directed_corners();
    test_random_traffic(50, 30, 65, 1'b1);
    test_random_traffic(50, 30, 65, 1'b0);
    test_random_traffic(50, 65, 30, 1'b1);
    test_random_traffic(50, 65, 30, 1'b0);
    test_output_backpressure();
    test_random_traffic(50, 0, 0, 1'b1);
    test_random_traffic(50, 0, 0, 1'b0);

    // drain, then watch for stray weights
    stop_input();
    wait_drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (expected_weights.size() != 0) begin
      error_count++;
      $display("%0d expected weights never arrived", expected_weights.size());
    end

    $display("Sent %0d entries under %0d delta settings, %0d weights checked.",
             entries_sent, settings_used, weights_checked);
    $display("Input was stalled for %0d cycles, %0d errors found.",
             input_stalls, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
